FILE: design/prsa_pkg.sv
// Shared constants, types and the arctangent table for the point rotate/scale core.
package prsa_pkg;

  localparam int COORD_FRAC_BITS  = 8;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int CX_W   = 58;
  localparam int CZ_W   = 30;
  localparam int ATAN_W = 25;

  localparam logic signed [CZ_W-1:0] PI_Q24      = 30'sd52707179;
  localparam logic signed [CZ_W-1:0] HALF_PI_Q24 = 30'sd26353589;
  localparam logic signed [CX_W-1:0] CORDIC_K_Q30 = 58'sd652032874;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_ctrl_t;

  function automatic logic [ATAN_W-1:0] atan_q24(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 25'd13176795;
      5'd1:  v = 25'd7778716;
      5'd2:  v = 25'd4110060;
      5'd3:  v = 25'd2086331;
      5'd4:  v = 25'd1047214;
      5'd5:  v = 25'd524117;
      5'd6:  v = 25'd262123;
      5'd7:  v = 25'd131069;
      5'd8:  v = 25'd65536;
      5'd9:  v = 25'd32768;
      5'd10: v = 25'd16384;
      5'd11: v = 25'd8192;
      5'd12: v = 25'd4096;
      5'd13: v = 25'd2048;
      5'd14: v = 25'd1024;
      5'd15: v = 25'd512;
      5'd16: v = 25'd256;
      5'd17: v = 25'd128;
      5'd18: v = 25'd64;
      5'd19: v = 25'd32;
      5'd20: v = 25'd16;
      5'd21: v = 25'd8;
      5'd22: v = 25'd4;
      5'd23: v = 25'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/prsa_cordic.sv
// Shared CORDIC stage: one micro-rotation per cycle, vectoring or rotation mode.
module prsa_cordic #(
  parameter int STEPS = prsa_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  prsa_pkg::cordic_ctrl_t              ctrl,
  input  logic signed [prsa_pkg::CX_W-1:0]    x_init,
  input  logic signed [prsa_pkg::CX_W-1:0]    y_init,
  input  logic signed [prsa_pkg::CZ_W-1:0]    z_init,
  output logic signed [prsa_pkg::CX_W-1:0]    x,
  output logic signed [prsa_pkg::CX_W-1:0]    y,
  output logic signed [prsa_pkg::CZ_W-1:0]    z,
  output logic                                done
);
  import prsa_pkg::*;

  localparam int STEP_W = $clog2(STEPS);

  logic              active;
  logic              mode;
  logic [STEP_W-1:0] cnt;
  logic signed [CX_W-1:0] xs, ys;
  logic signed [CZ_W-1:0] ang;
  logic              dir;

  always_comb begin
    xs  = x >>> cnt;
    ys  = y >>> cnt;
    ang = $signed({{(CZ_W-ATAN_W){1'b0}}, atan_q24(5'(cnt))});
    // dir high: turn counterclockwise, angle accumulator goes down
    dir = mode ? !z[CZ_W-1] : y[CX_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      mode   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        active <= 1'b1;
        mode   <= ctrl.rotate;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x <= x_init;
      y <= y_init;
      z <= z_init;
    end else if (active) begin
      if (dir) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ang;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ang;
      end
    end
  end

endmodule

FILE: design/point_rotate_scale_about_anchor_core.sv
// Point rotate/scale core: scales and turns each point about the anchor, transform latched per set.
// The first point of a set runs a setup pass: two squares on the shared multiplier, a
// bit-serial square root, a restoring divide, the scale-gain multiply, and two CORDIC passes
// (bearing, then cos/sin) on one shared CORDIC stage, with the rotation-gain multiply and the
// angle wrap between them. Every point then runs six products through the single registered
// multiplier plus rounding and output. in_ready is high only while the core is idle; a
// finished result sits in the output register until taken. A set whose target or reference
// distance is degenerate passes its points through unchanged after the short check.
// Configuration registers are written through wr_en/wr_index/wr_data; the anchor is used
// live, the rest at set start.
module point_rotate_scale_about_anchor_core #(
  parameter int CORDIC_STEPS = prsa_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [23:0]        wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic               out_last
);
  import prsa_pkg::*;

  localparam logic [2:0] REG_ANCHOR_X  = 3'd0;
  localparam logic [2:0] REG_ANCHOR_Y  = 3'd1;
  localparam logic [2:0] REG_REF_ANGLE = 3'd2;
  localparam logic [2:0] REG_REF_DIST  = 3'd3;
  localparam logic [2:0] REG_TARGET_X  = 3'd4;
  localparam logic [2:0] REG_TARGET_Y  = 3'd5;
  localparam logic [2:0] REG_SCALE_G   = 3'd6;
  localparam logic [2:0] REG_ROT_G     = 3'd7;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SQX   = 5'd1;
  localparam logic [4:0] S_SQY   = 5'd2;
  localparam logic [4:0] S_SUM   = 5'd3;
  localparam logic [4:0] S_CHK   = 5'd4;
  localparam logic [4:0] S_SQRT  = 5'd5;
  localparam logic [4:0] S_DINIT = 5'd6;
  localparam logic [4:0] S_DIV   = 5'd7;
  localparam logic [4:0] S_GAIN  = 5'd8;
  localparam logic [4:0] S_SCALE = 5'd9;
  localparam logic [4:0] S_VEC   = 5'd10;
  localparam logic [4:0] S_VWAIT = 5'd11;
  localparam logic [4:0] S_RMUL  = 5'd12;
  localparam logic [4:0] S_RSH   = 5'd13;
  localparam logic [4:0] S_WRAP  = 5'd14;
  localparam logic [4:0] S_FOLD  = 5'd15;
  localparam logic [4:0] S_RWAIT = 5'd16;
  localparam logic [4:0] S_TRIG  = 5'd17;
  localparam logic [4:0] S_M1    = 5'd18;
  localparam logic [4:0] S_M2    = 5'd19;
  localparam logic [4:0] S_M3    = 5'd20;
  localparam logic [4:0] S_M4    = 5'd21;
  localparam logic [4:0] S_M5    = 5'd22;
  localparam logic [4:0] S_M6    = 5'd23;
  localparam logic [4:0] S_M7    = 5'd24;
  localparam logic [4:0] S_M8    = 5'd25;
  localparam logic [4:0] S_OUT   = 5'd26;

  localparam int MA_W   = 42;
  localparam int MB_W   = 25;
  localparam int PROD_W = MA_W + MB_W;

  localparam logic [5:0] SQRT_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST  = 6'd40;

  // degenerate distance limits: v * 1e6 < 2^(2F) and ref * 1000 < 2^F
  localparam logic [49:0] BYP_SUM_MAX = 50'(((64'd1 << (2 * COORD_FRAC_BITS)) - 64'd1) / 1000000);
  localparam logic [22:0] BYP_REF_MAX = 23'(((32'd1 << COORD_FRAC_BITS) - 32'd1) / 1000);

  logic [4:0] state;

  logic signed [23:0] anchor_x, anchor_y, target_x, target_y;
  logic signed [15:0] reference_angle;
  logic [22:0]        reference_distance;
  logic [15:0]        scale_gain, rotation_gain;
  logic [15:0]        g_scale, g_rot;

  logic signed [23:0] px, py;
  logic               plast;
  logic signed [23:0] res_x, res_y;

  logic [31:0]        derived_scale;
  logic signed [17:0] rotation_cosine, rotation_sine;
  logic               setup_done, bypass_mode;
  logic               flip;

  logic signed [PROD_W-1:0] prod, acc;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;

  logic [49:0] sum_r;
  logic [63:0] sq_rem, sq_root, sq_bit, sq_trial;
  logic [5:0]  cnt;
  logic [40:0] div_num;
  logic [23:0] div_rem;
  logic [24:0] div_sh;

  logic signed [40:0]   sx, sy;
  logic signed [CZ_W-1:0] rz, fz;
  logic                 fflip;

  logic signed [24:0] dx, dy, dpx, dpy;
  logic signed [41:0] gv;
  logic signed [30:0] zdiff;
  logic signed [PROD_W-1:0] rnd_a, rnd_p, sc_w, ox_w, oy_w;
  logic signed [CX_W-1:0] vx, vy, tc, ts;
  logic signed [17:0] cos_c, sin_c;

  cordic_ctrl_t            cctrl;
  logic signed [CX_W-1:0]  cx_init, cy_init, cx, cy;
  logic signed [CZ_W-1:0]  cz_init, cz;
  logic                    cdone;

  function automatic logic signed [23:0] sat24(input logic signed [PROD_W-1:0] v);
    logic signed [23:0] r;
    if (v > PROD_W'(8388607)) r = 24'sd8388607;
    else if (v < -PROD_W'(8388608)) r = -24'sd8388608;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic signed [17:0] trig_clamp(input logic signed [CX_W-1:0] v);
    logic signed [17:0] r;
    if (v > CX_W'(65536)) r = 18'sd65536;
    else if (v < -CX_W'(65536)) r = -18'sd65536;
    else r = v[17:0];
    return r;
  endfunction

  prsa_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (cctrl),
    .x_init (cx_init),
    .y_init (cy_init),
    .z_init (cz_init),
    .x      (cx),
    .y      (cy),
    .z      (cz),
    .done   (cdone)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    g_scale = (scale_gain > 16'd32768) ? 16'd32768 : scale_gain;
    g_rot   = (rotation_gain > 16'd32768) ? 16'd32768 : rotation_gain;
    dx  = {target_x[23], target_x} - {anchor_x[23], anchor_x};
    dy  = {target_y[23], target_y} - {anchor_y[23], anchor_y};
    dpx = {px[23], px} - {anchor_x[23], anchor_x};
    dpy = {py[23], py} - {anchor_y[23], anchor_y};
    gv    = $signed({1'b0, div_num}) - 42'sd65536;
    zdiff = {cz[CZ_W-1], cz} - {{4{reference_angle[15]}}, reference_angle, 11'b0};

    rnd_a = (acc + PROD_W'(32768)) >>> 16;
    rnd_p = (prod + PROD_W'(32768)) >>> 16;
    sc_w  = PROD_W'(65536) + (prod >>> 15);
    ox_w  = rnd_a + {{(PROD_W-24){anchor_x[23]}}, anchor_x};
    oy_w  = rnd_a + {{(PROD_W-24){anchor_y[23]}}, anchor_y};

    sq_trial = sq_root + sq_bit;
    div_sh   = {div_rem, div_num[40]};

    tc = (cx + CX_W'(8192)) >>> 14;
    ts = (cy + CX_W'(8192)) >>> 14;
    cos_c = trig_clamp(tc);
    sin_c = trig_clamp(ts);

    fz = rz;
    fflip = 1'b0;
    if (rz > HALF_PI_Q24) begin
      fz = rz - PI_Q24;
      fflip = 1'b1;
    end else if (rz < -HALF_PI_Q24) begin
      fz = rz + PI_Q24;
      fflip = 1'b1;
    end

    // vectoring start: a target left of the anchor is turned by a half turn first
    vx = {{3{dx[24]}}, dx, 30'b0};
    vy = {{3{dy[24]}}, dy, 30'b0};
    cx_init = vx;
    cy_init = vy;
    cz_init = '0;
    if (state == S_FOLD) begin
      cx_init = CORDIC_K_Q30;
      cy_init = '0;
      cz_init = fz;
    end else if (dx[24]) begin
      cx_init = -vx;
      cy_init = -vy;
      cz_init = dy[24] ? -PI_Q24 : PI_Q24;
    end
    cctrl.start  = (state == S_VEC) || (state == S_FOLD);
    cctrl.rotate = (state == S_FOLD);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX: begin
        mul_a = {{17{dx[24]}}, dx};
        mul_b = dx;
      end
      S_SQY: begin
        mul_a = {{17{dy[24]}}, dy};
        mul_b = dy;
      end
      S_GAIN: begin
        mul_a = gv;
        mul_b = {9'b0, g_scale};
      end
      S_RMUL: begin
        mul_a = {{11{zdiff[30]}}, zdiff};
        mul_b = {9'b0, g_rot};
      end
      S_M1: begin
        mul_a = {10'b0, derived_scale};
        mul_b = dpx;
      end
      S_M2: begin
        mul_a = {10'b0, derived_scale};
        mul_b = dpy;
      end
      S_M3: begin
        mul_a = {sx[40], sx};
        mul_b = {{7{rotation_cosine[17]}}, rotation_cosine};
      end
      S_M4: begin
        mul_a = {sy[40], sy};
        mul_b = {{7{rotation_sine[17]}}, rotation_sine};
      end
      S_M5: begin
        mul_a = {sx[40], sx};
        mul_b = {{7{rotation_sine[17]}}, rotation_sine};
      end
      S_M6: begin
        mul_a = {sy[40], sy};
        mul_b = {{7{rotation_cosine[17]}}, rotation_cosine};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x           <= '0;
      anchor_y           <= '0;
      reference_angle    <= '0;
      reference_distance <= '0;
      target_x           <= '0;
      target_y           <= '0;
      scale_gain         <= 16'd32768;
      rotation_gain      <= 16'd32768;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ANCHOR_X:  anchor_x           <= wr_data;
        REG_ANCHOR_Y:  anchor_y           <= wr_data;
        REG_REF_ANGLE: reference_angle    <= wr_data[15:0];
        REG_REF_DIST:  reference_distance <= wr_data[22:0];
        REG_TARGET_X:  target_x           <= wr_data;
        REG_TARGET_Y:  target_y           <= wr_data;
        REG_SCALE_G:   scale_gain         <= wr_data[15:0];
        REG_ROT_G:     rotation_gain      <= wr_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      setup_done  <= 1'b0;
      bypass_mode <= 1'b0;
      out_valid   <= 1'b0;
      cnt         <= '0;
    end else begin
      if (state == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (!setup_done) state <= S_SQX;
            else if (bypass_mode) state <= S_OUT;
            else state <= S_M1;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: state <= S_SUM;
        S_SUM: state <= S_CHK;
        S_CHK: begin
          cnt <= '0;
          if (sum_r <= BYP_SUM_MAX || reference_distance <= BYP_REF_MAX) begin
            bypass_mode <= 1'b1;
            setup_done  <= 1'b1;
            state       <= S_OUT;
          end else begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == SQRT_LAST) state <= S_DINIT;
        end
        S_DINIT: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) state <= S_GAIN;
        end
        S_GAIN:  state <= S_SCALE;
        S_SCALE: state <= S_VEC;
        S_VEC:   state <= S_VWAIT;
        S_VWAIT: if (cdone) state <= S_RMUL;
        S_RMUL:  state <= S_RSH;
        S_RSH:   state <= S_WRAP;
        S_WRAP: begin
          if (rz <= PI_Q24 && rz >= -PI_Q24) state <= S_FOLD;
        end
        S_FOLD:  state <= S_RWAIT;
        S_RWAIT: if (cdone) state <= S_TRIG;
        S_TRIG: begin
          setup_done  <= 1'b1;
          bypass_mode <= 1'b0;
          state       <= S_M1;
        end
        S_M1: state <= S_M2;
        S_M2: state <= S_M3;
        S_M3: state <= S_M4;
        S_M4: state <= S_M5;
        S_M5: state <= S_M6;
        S_M6: state <= S_M7;
        S_M7: state <= S_M8;
        S_M8: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || out_ready) begin
            if (plast) setup_done <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          px    <= point_x;
          py    <= point_y;
          plast <= last_point;
          res_x <= point_x;
          res_y <= point_y;
        end
      end
      S_SQY: acc <= prod;
      S_SUM: sum_r <= 50'(acc + prod);
      S_CHK: begin
        sq_rem  <= {sum_r, 14'b0};
        sq_root <= '0;
        sq_bit  <= 64'd1 << 62;
      end
      S_SQRT: begin
        if (sq_rem >= sq_trial) begin
          sq_rem  <= sq_rem - sq_trial;
          sq_root <= (sq_root >> 1) + sq_bit;
        end else begin
          sq_root <= sq_root >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      S_DINIT: begin
        div_num <= {sq_root[31:0], 9'b0};
        div_rem <= '0;
      end
      S_DIV: begin
        if (div_sh >= {2'b0, reference_distance}) begin
          div_rem <= 24'(div_sh - {2'b0, reference_distance});
          div_num <= {div_num[39:0], 1'b1};
        end else begin
          div_rem <= div_sh[23:0];
          div_num <= {div_num[39:0], 1'b0};
        end
      end
      S_SCALE: begin
        if (sc_w < PROD_W'(5243)) derived_scale <= 32'd5243;
        else if (sc_w > PROD_W'(33'h0FFFFFFFF)) derived_scale <= 32'hFFFFFFFF;
        else derived_scale <= sc_w[31:0];
      end
      S_RSH: rz <= CZ_W'(prod >>> 15);
      S_WRAP: begin
        if (rz > PI_Q24) rz <= rz - (PI_Q24 <<< 1);
        else if (rz < -PI_Q24) rz <= rz + (PI_Q24 <<< 1);
      end
      S_FOLD: flip <= fflip;
      S_TRIG: begin
        rotation_cosine <= flip ? -cos_c : cos_c;
        rotation_sine   <= flip ? -sin_c : sin_c;
      end
      S_M2: sx <= rnd_p[40:0];
      S_M3: sy <= rnd_p[40:0];
      S_M4: acc <= prod;
      S_M5: acc <= acc - prod;
      S_M6: begin
        res_x <= sat24(ox_w);
        acc   <= prod;
      end
      S_M7: acc <= acc + prod;
      S_M8: res_y <= sat24(oy_w);
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_x    <= res_x;
          out_y    <= res_y;
          out_last <= plast;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sim/tb.sv
// Testbench for the point rotate/scale core: queue-fed driver, monitor and bit-exact predictor.
`timescale 1ns / 100ps

module tb;
  import prsa_pkg::*;

  localparam longint PI_L   = 52707179;
  localparam longint KCOS_L = 652032874;

  localparam logic [2:0] REG_ANCHOR_X   = 3'd0;
  localparam logic [2:0] REG_ANCHOR_Y   = 3'd1;
  localparam logic [2:0] REG_REF_ANGLE  = 3'd2;
  localparam logic [2:0] REG_REF_DIST   = 3'd3;
  localparam logic [2:0] REG_TARGET_X   = 3'd4;
  localparam logic [2:0] REG_TARGET_Y   = 3'd5;
  localparam logic [2:0] REG_SCALE_GAIN = 3'd6;
  localparam logic [2:0] REG_ROT_GAIN   = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               last;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [23:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] point_x = '0;
  logic signed [23:0] point_y = '0;
  logic last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] out_x;
  logic signed [23:0] out_y;
  logic out_last;

  point_rotate_scale_about_anchor_core dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  point_t pending_pts[$];
  point_t expected_pts[$];
  idle_mode_t idle_mode = IDLE_NONE;
  logic hold_phase = 1'b0;
  int hold_cnt = 0;
  logic in_fire = 1'b0;
  int mismatches = 0;

  // mirror of the core's registers and latched transform
  logic [23:0] regs[8];
  longint unsigned xf_scale;
  longint xf_cos, xf_sin;
  bit xf_latched, xf_bypass;

  longint atan_tbl[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
    131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint sx24(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint sat24(longint v);
    return v < -8388608 ? -8388608 : (v > 8388607 ? 8388607 : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem, root, b;
    rem = v; root = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint bearing_of(longint dx, longint dy);
    longint x, y, z, xs, ys;
    x = dx * 1073741824; y = dy * 1073741824; z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_L : -PI_L;
      x = -x; y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_tbl[i];
      end else begin
        x -= ys; y += xs; z -= atan_tbl[i];
      end
    end
    return z;
  endfunction

  task automatic latch_trig(longint r);
    longint x, y, xs, ys, c, s;
    bit flip;
    x = KCOS_L; y = 0; flip = 0;
    while (r > PI_L) r -= 2 * PI_L;
    while (r < -PI_L) r += 2 * PI_L;
    if (r > PI_L / 2) begin
      r -= PI_L; flip = 1;
    end else if (r < -(PI_L / 2)) begin
      r += PI_L; flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (r >= 0) begin
        x -= ys; y += xs; r -= atan_tbl[i];
      end else begin
        x += ys; y -= xs; r += atan_tbl[i];
      end
    end
    c = (x + 8192) >>> 14; s = (y + 8192) >>> 14;
    c = c < -65536 ? -65536 : (c > 65536 ? 65536 : c);
    s = s < -65536 ? -65536 : (s > 65536 ? 65536 : s);
    xf_cos = flip ? -c : c;
    xf_sin = flip ? -s : s;
  endtask

  task automatic latch_transform();
    longint dx, dy, raw, sc, rot, sg, rg;
    longint unsigned sum, refd, distv;
    dx = sx24(regs[REG_TARGET_X]) - sx24(regs[REG_ANCHOR_X]);
    dy = sx24(regs[REG_TARGET_Y]) - sx24(regs[REG_ANCHOR_Y]);
    refd = regs[REG_REF_DIST][22:0];
    sum = longint'(dx * dx) + longint'(dy * dy);
    xf_latched = 1;
    if ((sum < 65536 && sum * 1000000 < 65536) || refd * 1000 < 256) begin
      xf_bypass = 1;
      return;
    end
    xf_bypass = 0;
    sg = regs[REG_SCALE_GAIN][15:0] > 32768 ? 32768 : regs[REG_SCALE_GAIN][15:0];
    rg = regs[REG_ROT_GAIN][15:0] > 32768 ? 32768 : regs[REG_ROT_GAIN][15:0];
    distv = int_sqrt(sum << 14);
    raw = longint'((distv << 9) / refd);
    sc = 65536 + (((raw - 65536) * sg) >>> 15);
    if (sc < 5243) sc = 5243;
    if (sc > 64'sh0FFFFFFFF) sc = 64'sh0FFFFFFFF;
    xf_scale = sc;
    rot = ((bearing_of(dx, dy) - sx24({{8{regs[REG_REF_ANGLE][15]}},
          regs[REG_REF_ANGLE][15:0]}) * 2048) * rg) >>> 15;
    latch_trig(rot);
  endtask

  task automatic predict_point(point_t p);
    point_t r;
    longint ax, ay, sxv, syv, sc;
    if (!xf_latched) latch_transform();
    r = p;
    if (!xf_bypass) begin
      ax = sx24(regs[REG_ANCHOR_X]); ay = sx24(regs[REG_ANCHOR_Y]);
      sc = longint'(xf_scale);
      sxv = ((sx24(p.x) - ax) * sc + 32768) >>> 16;
      syv = ((sx24(p.y) - ay) * sc + 32768) >>> 16;
      r.x = 24'(sat24(ax + ((sxv * xf_cos - syv * xf_sin + 32768) >>> 16)));
      r.y = 24'(sat24(ay + ((sxv * xf_sin + syv * xf_cos + 32768) >>> 16)));
    end
    expected_pts = {expected_pts, r};
    if (p.last) xf_latched = 0;
  endtask

  // input side: acceptance is seen at the rising edge, the next item loaded at the falling one
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) predict_point({point_x, point_y, last_point});
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (pending_pts.size() > 0 &&
          !(idle_mode == IDLE_SENDER ? $urandom_range(99) < 88 :
            idle_mode == IDLE_BOTH ? $urandom_range(99) < 10 : 0)) begin
        point_t p;
        p = pending_pts.pop_front();
        point_x <= p.x; point_y <= p.y; last_point <= p.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_phase && hold_cnt < 400) begin
      hold_cnt <= hold_cnt + 1;
      out_ready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_ready <= $urandom_range(99) >= 88;
        IDLE_BOTH:     out_ready <= $urandom_range(99) >= 10;
        default:       out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: %0d %0d %0b", out_x, out_y, out_last);
      end else begin
        point_t e;
        e = expected_pts.pop_front();
        if (e.x !== out_x || e.y !== out_y || e.last !== out_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0b got %0d %0d %0b",
                     e.x, e.y, e.last, out_x, out_y, out_last);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    case (idx) inside
      REG_REF_ANGLE, REG_SCALE_GAIN, REG_ROT_GAIN: regs[idx] = {8'd0, val[15:0]};
      REG_REF_DIST: regs[idx] = {1'b0, val[22:0]};
      default: regs[idx] = val;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic logic [23:0] coord_pick();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom());
      default: return 24'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  task automatic add_point(logic [23:0] x, logic [23:0] y, logic last);
    point_t p;
    p.x = x; p.y = y; p.last = last;
    pending_pts = {pending_pts, p};
  endtask

  // check just after the falling edge, once the driver's updates have settled
  task automatic drain();
    forever begin
      @(negedge clk);
      #1;
      if (pending_pts.size() == 0 && !in_valid && expected_pts.size() == 0) break;
    end
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int n;
    regs = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd32768, 24'd32768};
    xf_latched = 0; xf_bypass = 0; xf_scale = 0; xf_cos = 0; xf_sin = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset registers: reference distance zero, so the set passes through
    add_point(24'h7FFFFF, 24'h800000, 1'b0);
    add_point(24'h800000, 24'h7FFFFF, 1'b1);
    drain();
    // normal drag, full gains; set left open across the anchor change
    write_reg(REG_REF_DIST, 24'd2560);
    write_reg(REG_TARGET_X, 24'd3000);
    write_reg(REG_TARGET_Y, 24'd1000);
    add_point(24'd256, 24'd512, 1'b0);
    add_point(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    add_point(24'h800000, 24'h800000, 1'b0);
    drain();
    write_reg(REG_ANCHOR_X, 24'd500);
    write_reg(REG_TARGET_X, -24'd3000);  // only seen at the next set
    add_point(24'd100, -24'd100, 1'b1);
    drain();
    // target on the anchor: bypass
    write_reg(REG_TARGET_X, 24'd500);
    write_reg(REG_TARGET_Y, 24'd0);
    add_point(24'd1234, 24'd4321, 1'b1);
    drain();
    // bearing with negative x, gains above one, largest reference angle
    write_reg(REG_TARGET_X, 24'h800000);
    write_reg(REG_TARGET_Y, 24'd5);
    write_reg(REG_SCALE_GAIN, 24'hFFFF);
    write_reg(REG_ROT_GAIN, 24'hFFFF);
    write_reg(REG_REF_ANGLE, 24'h7FFF);
    add_point(24'd9000, 24'd9000, 1'b1);
    drain();
    // scale saturation: tiny reference, far target
    write_reg(REG_REF_DIST, 24'd1);
    write_reg(REG_REF_ANGLE, 24'h8000);
    add_point(24'd600, 24'd0, 1'b1);
    add_point(24'd501, 24'd1, 1'b1);
    drain();
    // scale floor: target close to anchor, huge reference, zero rotation gain
    write_reg(REG_REF_DIST, 24'h7FFFFF);
    write_reg(REG_TARGET_X, 24'd510);
    write_reg(REG_ROT_GAIN, 24'd0);
    add_point(-24'd40000, 24'd70000, 1'b1);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      if (ph % 3 == 0) begin
        write_reg(REG_ANCHOR_X, coord_pick());
        write_reg(REG_ANCHOR_Y, coord_pick());
      end
      write_reg(REG_REF_ANGLE, 24'($urandom()));
      write_reg(REG_REF_DIST, ph == 5 ? 24'd0 : ($urandom_range(1) ? 24'($urandom()) :
                24'($urandom_range(65536, 1))));
      write_reg(REG_TARGET_X, coord_pick());
      write_reg(REG_TARGET_Y, coord_pick());
      write_reg(REG_SCALE_GAIN, ph == 7 ? 24'd0 : (ph == 8 ? 24'd32768 : 24'($urandom())));
      write_reg(REG_ROT_GAIN, ph == 9 ? 24'd0 : 24'($urandom()));
      idle_mode = idle_mode_t'(ph % 4);
      hold_phase = (ph == 2);
      n = 0;
      while (n < 100) begin
        int len;
        len = $urandom_range(6, 1);
        for (int k = 0; k < len; k++)
          add_point(coord_pick(), coord_pick(), k == len - 1 || $urandom_range(30) == 0);
        n += len;
      end
      if (ph % 5 == 4) add_point(coord_pick(), coord_pick(), 1'b0);  // set left open
      drain();
    end

    if (mismatches == 0 && expected_pts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
design/prsa_pkg.sv
design/prsa_cordic.sv
design/point_rotate_scale_about_anchor_core.sv
sim/tb.sv
